// ===== rtl/core/apng_pkg.sv =====
// shared types, widths and codes for the accumulated pixel normalize and gap-fill block
package apng_pkg;

	localparam int SumBits    = 24;
	localparam int CountBits  = 16;
	localparam int ChanBits   = 8;
	localparam int DivBits    = (SumBits > CountBits + ChanBits) ? SumBits : CountBits + ChanBits;
	localparam int StepBits   = $clog2(ChanBits);
	localparam int CfgIdxBits = 2;
	localparam int QueueDepth = 2;
	localparam int QPtrBits   = $clog2(QueueDepth);

	typedef enum logic [CfgIdxBits-1:0] {
		CFG_BG_BLUE  = 2'd0,
		CFG_BG_GREEN = 2'd1,
		CFG_BG_RED   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [SumBits-1:0]   sum_blue;
		logic [SumBits-1:0]   sum_green;
		logic [SumBits-1:0]   sum_red;
		logic [CountBits-1:0] hit_count;
		logic                 row_last;
	} point_t;

	typedef struct packed {
		logic [ChanBits-1:0] blue;
		logic [ChanBits-1:0] green;
		logic [ChanBits-1:0] red;
		logic                end_of_row;
	} pixel_out_t;

	typedef struct packed {
		logic [ChanBits-1:0] red;
		logic [ChanBits-1:0] green;
		logic [ChanBits-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic   blank;
		point_t point;
	} queue_item_t;

	typedef struct packed {
		logic                 start;
		logic [SumBits-1:0]   sum_blue;
		logic [SumBits-1:0]   sum_green;
		logic [SumBits-1:0]   sum_red;
		logic [CountBits-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic done;
		rgb_t pixel;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_MERGE,
		ST_EMIT_HELD,
		ST_EMIT_LAST
	} back_state_t;

endpackage

// ===== rtl/core/apng_front.sv =====
// front end: accepts points, marks blank ones and queues them for the back end
module apng_front import apng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pt_valid,
	output logic        pt_ready,
	input  point_t      point,
	output logic        q_valid,
	output queue_item_t q_item,
	input  logic        q_pop
);

	queue_item_t         entry_q [QueueDepth];
	logic [QPtrBits-1:0] wr_ptr_q;
	logic [QPtrBits-1:0] rd_ptr_q;
	logic [QPtrBits:0]   fill_q;
	logic                push;
	queue_item_t         new_item;

	assign pt_ready = (fill_q != (QPtrBits+1)'(QueueDepth));
	assign push     = pt_valid && pt_ready;
	assign q_valid  = (fill_q != '0);
	assign q_item   = entry_q[rd_ptr_q];

	// blank point: no samples hit it
	always_comb begin
		new_item.point = point;
		new_item.blank = (point.hit_count == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// ===== rtl/core/apng_div.sv =====
// three-lane restoring divider, one quotient bit per cycle, saturating at full scale
module apng_div import apng_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [StepBits-1:0] LastStep = StepBits'(ChanBits - 1);

	logic [DivBits-1:0]  rem_q [3];
	logic [ChanBits-1:0] quo_q [3];
	logic [2:0]          sat_q;
	logic [DivBits-1:0]  dsh_q;
	logic [StepBits-1:0] step_q;
	logic                run_q;
	logic                done_q;
	logic [SumBits-1:0]  sum_in [3];
	logic [DivBits-1:0]  limit;

	assign sum_in[0] = req.sum_blue;
	assign sum_in[1] = req.sum_green;
	assign sum_in[2] = req.sum_red;

	// quotient overflows a byte when sum >= count * 256
	assign limit = DivBits'({req.count, ChanBits'(0)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == LastStep);
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LastStep) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsh_q <= DivBits'(req.count) << (ChanBits - 1);
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= DivBits'(sum_in[c]);
				sat_q[c] <= (DivBits'(sum_in[c]) >= limit);
				quo_q[c] <= '0;
			end
		end else if (run_q) begin
			dsh_q <= dsh_q >> 1;
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= dsh_q) begin
					rem_q[c] <= rem_q[c] - dsh_q;
					quo_q[c] <= {quo_q[c][ChanBits-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][ChanBits-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		rsp.done        = done_q;
		rsp.pixel.blue  = sat_q[0] ? '1 : quo_q[0];
		rsp.pixel.green = sat_q[1] ? '1 : quo_q[1];
		rsp.pixel.red   = sat_q[2] ? '1 : quo_q[2];
	end

endmodule

// ===== rtl/core/apng_back.sv =====
// back end: sequences division, gap fill and the one-behind pixel output
module apng_back import apng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  queue_item_t q_item,
	output logic        q_pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	input  rgb_t        background,
	output logic        px_valid,
	input  logic        px_ready,
	output pixel_out_t  pixel
);

	back_state_t state_q;
	back_state_t state_d;
	rgb_t        cur_q;
	rgb_t        held_q;
	rgb_t        left_q;
	logic        held_valid_q;
	logic        seen_q;
	logic        gap_q;
	logic        last_q;
	logic        blank_q;
	logic        px_valid_q;
	pixel_out_t  pixel_q;
	logic        slot_free;
	logic        load_held;
	logic        advance_held;
	logic        load_last;

	function automatic rgb_t halve_sum(rgb_t a, rgb_t b);
		rgb_t r;
		r.blue  = (a.blue >> 1) + (b.blue >> 1);
		r.green = (a.green >> 1) + (b.green >> 1);
		r.red   = (a.red >> 1) + (b.red >> 1);
		return r;
	endfunction

	assign slot_free = !px_valid_q || px_ready;
	assign px_valid  = px_valid_q;
	assign pixel     = pixel_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_item.blank ? ST_MERGE : ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				state_d = ST_EMIT_HELD;
			end
			ST_EMIT_HELD: begin
				if (!held_valid_q || slot_free) begin
					state_d = last_q ? ST_EMIT_LAST : ST_IDLE;
				end
			end
			ST_EMIT_LAST: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop             = (state_q == ST_IDLE) && q_valid;
		div_req.start     = q_pop && !q_item.blank;
		div_req.sum_blue  = q_item.point.sum_blue;
		div_req.sum_green = q_item.point.sum_green;
		div_req.sum_red   = q_item.point.sum_red;
		div_req.count     = q_item.point.hit_count;
		advance_held      = (state_q == ST_EMIT_HELD) && (!held_valid_q || slot_free);
		load_held         = (state_q == ST_EMIT_HELD) && held_valid_q && slot_free;
		load_last         = (state_q == ST_EMIT_LAST) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_valid_q <= 1'b0;
			seen_q       <= 1'b0;
			gap_q        <= 1'b0;
			px_valid_q   <= 1'b0;
			held_q       <= '0;
			left_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MERGE) begin
				if (blank_q) begin
					if (seen_q) begin
						gap_q <= 1'b1;
					end
				end else begin
					if (gap_q && held_valid_q) begin
						held_q <= halve_sum(left_q, cur_q);
					end
					gap_q  <= 1'b0;
					seen_q <= 1'b1;
				end
			end
			if (advance_held) begin
				if (held_valid_q) begin
					left_q <= held_q;
				end
				held_q       <= cur_q;
				held_valid_q <= 1'b1;
			end
			if (load_last) begin
				held_valid_q <= 1'b0;
				seen_q       <= 1'b0;
				gap_q        <= 1'b0;
				left_q       <= '0;
			end
			if (load_held || load_last) begin
				px_valid_q <= 1'b1;
			end else if (px_ready) begin
				px_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			last_q  <= q_item.point.row_last;
			blank_q <= q_item.blank;
			if (q_item.blank) begin
				cur_q <= background;
			end
		end else if ((state_q == ST_DIVIDE) && div_rsp.done) begin
			cur_q <= div_rsp.pixel;
		end
		if (load_held || load_last) begin
			pixel_q.blue       <= held_q.blue;
			pixel_q.green      <= held_q.green;
			pixel_q.red        <= held_q.red;
			pixel_q.end_of_row <= load_last;
		end
	end

endmodule

// ===== rtl/core/accumulated_pixel_normalize_gapfill.sv =====
// top level: background registers, point queue, divider and gap-fill output stage
//
//  channel  | signals                          | word
//  ---------+----------------------------------+-------------------------------------
//  points   | pt_valid, pt_ready, point        | sums, hit count, row end mark
//  pixels   | px_valid, px_ready, pixel        | blue, green, red, end of row
//  config   | cfg_write, cfg_index, cfg_data   | background byte, index 0..2
//
//  back end states: idle, divide, merge, emit-held; a blank point skips divide,
//  a point that closes a row adds emit-last; divide waits on the 8-step divider
//  a two-word queue lets points arrive while the back end divides or waits
//  reset clears the queue, row state, output valid flag and background colour
//  a stalled pixel output holds the back end; the queue then fills and drops pt_ready
module accumulated_pixel_normalize_gapfill import apng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pt_valid,
	output logic                  pt_ready,
	input  point_t                point,
	output logic                  px_valid,
	input  logic                  px_ready,
	output pixel_out_t            pixel,
	input  logic                  cfg_write,
	input  logic [CfgIdxBits-1:0] cfg_index,
	input  logic [ChanBits-1:0]   cfg_data
);

	rgb_t        bg_q;
	logic        q_valid;
	queue_item_t q_item;
	logic        q_pop;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	// background colour registers, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BG_BLUE:  bg_q.blue  <= cfg_data;
				CFG_BG_GREEN: bg_q.green <= cfg_data;
				CFG_BG_RED:   bg_q.red   <= cfg_data;
				default:      bg_q       <= bg_q;
			endcase
		end
	end

	// front: accept and classify points
	apng_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.point    (point),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// three-lane divider, used by the back end
	apng_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: normalize, fill gaps, emit one pixel behind
	apng_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.background (bg_q),
		.px_valid   (px_valid),
		.px_ready   (px_ready),
		.pixel      (pixel)
	);

endmodule
